// File: sv/ftpg_pkg.sv
// ----------------------------------------------------------------------------
// ftpg_pkg: shared types and constants
// Key, hash and probe widths, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package ftpg_pkg;

  localparam int KEY_W    = 32;
  localparam int LFSR_W   = 16;
  localparam int NUM_W    = 6;
  localparam int TSL_W    = 5;
  localparam int LIM_W    = 7;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LIMIT    = 2'd1;

  localparam logic [TSL_W-1:0] TSL_RESET = 5'd13;
  localparam logic [LIM_W-1:0] LIM_RESET = 7'd8;

  typedef struct packed {
    logic [TSL_W-1:0] table_size_log2;
    logic [LIM_W-1:0] search_limit;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LFSR_W-1:0] hash1;
  } qent_t;

endpackage

// File: sv/ftpg_front.sv
// ----------------------------------------------------------------------------
// ftpg_front: key build and LFSR hash pipeline
// Builds the 32-bit key from the tuple and runs the LFSR hash over four
// stages, one key byte per stage, MSB first.
// ----------------------------------------------------------------------------
module ftpg_front import ftpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] dest_address,
  input  logic [15:0] dst_port,
  input  logic        is_tcp,
  input  logic        full_match,
  input  logic        is_transmit,
  input  logic [9:0]  queue_id,
  output logic        push,
  output qent_t       push_data,
  input  logic        q_ready
);

  localparam int NST = 4;

  function automatic logic [LFSR_W-1:0] lfsr8(input logic [LFSR_W-1:0] s,
                                               input logic [7:0] b);
    logic [LFSR_W-1:0] r;
    logic              fb;
    r = s;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ r[2] ^ b[i];
      r  = {r[14:0], fb};
    end
    return r;
  endfunction

  logic [NST-1:0]    vld_r;
  logic [KEY_W-1:0]  key_r  [NST];
  logic [LFSR_W-1:0] lfsr_r [NST];
  logic [NST-1:0]    open;

  logic [31:0] sa, da;
  logic [15:0] sp, dp, sp_w, dp_w;
  logic [9:0]  q;
  logic [KEY_W-1:0] key_in;

  always_comb begin
    q  = is_transmit ? queue_id : 10'd0;
    sa = source_address;
    sp = source_port;
    da = dest_address;
    dp = dst_port;
    if (!full_match) begin
      if (is_transmit) begin
        da = 32'd0;
        dp = 16'd0;
      end else begin
        sa = 32'd0;
        sp = 16'd0;
      end
    end
    sp_w = (!full_match && !is_tcp) ? dp : sp;
    dp_w = (!full_match && !is_tcp) ? sp : dp;
    key_in = {21'd0, q, ~is_tcp} ^ da ^ {dp_w, sa[31:16]} ^ {sa[15:0], sp_w};
  end

  always_comb begin
    open[NST-1] = !vld_r[NST-1] || q_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      open[i] = !vld_r[i] || open[i+1];
    end
  end

  assign in_ready  = open[0];
  assign push      = vld_r[NST-1] && q_ready;
  assign push_data = '{key: key_r[NST-1], hash1: lfsr_r[NST-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (open[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (open[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (open[0]) begin
      key_r[0]  <= key_in;
      lfsr_r[0] <= lfsr8(LFSR_SEED, key_in[31:24]);
    end
    for (int i = 1; i < NST; i++) begin
      if (open[i]) begin
        key_r[i]  <= key_r[i-1];
        lfsr_r[i] <= lfsr8(lfsr_r[i-1], key_r[i-1][31-8*i -: 8]);
      end
    end
  end

endmodule

// File: sv/ftpg_queue.sv
// ----------------------------------------------------------------------------
// ftpg_queue: hashed tuple queue
// Four-entry FIFO between the hash pipeline and the probe sequencer.
// ----------------------------------------------------------------------------
module ftpg_queue import ftpg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  ready,
  input  logic  pop,
  output logic  nempty,
  output qent_t head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  qent_t          mem_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;

  assign ready  = cnt_r != (PW+1)'(DEPTH);
  assign nempty = cnt_r != '0;
  assign head   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// File: sv/ftpg_back.sv
// ----------------------------------------------------------------------------
// ftpg_back: probe sequencer
// Pops one hashed tuple per run and walks hash1 + n*hash2 over the masked
// table, one probe per output beat.
// ----------------------------------------------------------------------------
module ftpg_back import ftpg_pkg::*; #(
  parameter int MAX_INDEX_BITS = 16,
  parameter int MAX_PROBES     = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      q_nempty,
  input  qent_t                     q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [MAX_INDEX_BITS-1:0] probe_index,
  output logic [NUM_W-1:0]          probe_number,
  output logic [KEY_W-1:0]          filter_key,
  output logic                      last_probe
);

  localparam int IW = MAX_INDEX_BITS;

  logic              run_r;
  logic [NUM_W-1:0]  cnt_r;
  logic [IW-1:0]     cur_r, step_r, mask_r;
  logic [KEY_W-1:0]  key_r;
  logic [LIM_W-1:0]  lim_r;

  logic [TSL_W-1:0]  bits_sat;
  logic [IW-1:0]     mask;
  logic [LIM_W-1:0]  lim;
  logic [KEY_W-1:0]  h2;
  logic              load;

  always_comb begin
    bits_sat = (cfg.table_size_log2 > TSL_W'(MAX_INDEX_BITS)) ?
               TSL_W'(MAX_INDEX_BITS) : cfg.table_size_log2;
    for (int i = 0; i < IW; i++) begin
      mask[i] = TSL_W'(i) < bits_sat;
    end
    if (cfg.search_limit == '0) begin
      lim = LIM_W'(1);
    end else if (cfg.search_limit > LIM_W'(MAX_PROBES)) begin
      lim = LIM_W'(MAX_PROBES);
    end else begin
      lim = cfg.search_limit;
    end
    h2 = {q_head.key[KEY_W-2:0], 1'b0} - KEY_W'(1);
  end

  assign last_probe   = ({1'b0, cnt_r} + LIM_W'(1)) == lim_r;
  assign load         = q_nempty && (!run_r || (out_ready && last_probe));
  assign q_pop        = load;
  assign out_valid    = run_r;
  assign probe_index  = cur_r;
  assign probe_number = cnt_r;
  assign filter_key   = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (load) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r && out_ready) begin
      if (last_probe) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r  <= q_head.hash1[IW-1:0] & mask;
      step_r <= h2[IW-1:0] & mask;
      mask_r <= mask;
      key_r  <= q_head.key;
      lim_r  <= lim;
    end else if (run_r && out_ready && !last_probe) begin
      cur_r <= (cur_r + step_r) & mask_r;
    end
  end

endmodule

// File: sv/filter_table_probe_generator_core.sv
// ----------------------------------------------------------------------------
// filter_table_probe_generator_core: filter table probe generator
// Turns IPv4 filter tuples into runs of double-hashed table probe indices.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one tuple per beat. in_tuser carries the TCP, full-match and
//            transmit flags. Accepted back to back while the four-stage
//            hash pipeline and its four-entry queue have room.
//   out_*  : one probe per beat; out_tlast marks the last probe of a run.
//            A run is search_limit beats (1..MAX_PROBES), default eight.
//   cfg_*  : register writes; write only while idle, which the block does not enforce.
// Path: input beat, four hash stages, queue, then the registered first probe of its run.
// Throughput: one output beat per cycle while a run is in progress and out_tready
//   is high; the probe sequencer steps once per accepted beat. Runs follow one
//   another with no gap while the queue holds a tuple.
// Reset: clears the pipeline, queue and sequencer; registers return to
//   table_size_log2 = 13, search_limit = 8.
// Stall: a low out_tready holds the current probe; the queue and then the
//   hash pipeline fill, after which in_tready drops.
// ----------------------------------------------------------------------------
module filter_table_probe_generator_core import ftpg_pkg::*; #(
  parameter int MAX_INDEX_BITS = 16,
  parameter int MAX_PROBES     = 64,
  localparam int OUT_W = ((MAX_INDEX_BITS + NUM_W + KEY_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // source_address[31:0], source_port[47:32], dest_address[79:48],
  // dst_port[95:80], queue_id[105:96], zero fill
  input  logic [111:0]         in_tdata,
  // is_tcp[0], full_match[1], is_transmit[2]
  input  logic [2:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // probe_index, probe_number, filter_key, zero fill
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [TSL_W-1:0] tsl_r;
  logic [LIM_W-1:0] lim_r;
  cfg_t             cfg;

  logic  push, q_ready, q_pop, q_nempty;
  qent_t push_data, q_head;

  logic [MAX_INDEX_BITS-1:0] probe_index;
  logic [NUM_W-1:0]          probe_number;
  logic [KEY_W-1:0]          filter_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsl_r <= TSL_RESET;
      lim_r <= LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE_LOG2: tsl_r <= cfg_data[TSL_W-1:0];
        REG_SEARCH_LIMIT:    lim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{table_size_log2: tsl_r, search_limit: lim_r};

  ftpg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .source_address (in_tdata[31:0]),
    .source_port    (in_tdata[47:32]),
    .dest_address   (in_tdata[79:48]),
    .dst_port       (in_tdata[95:80]),
    .is_tcp         (in_tuser[0]),
    .full_match     (in_tuser[1]),
    .is_transmit    (in_tuser[2]),
    .queue_id       (in_tdata[105:96]),
    .push           (push),
    .push_data      (push_data),
    .q_ready        (q_ready)
  );

  ftpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .ready     (q_ready),
    .pop       (q_pop),
    .nempty    (q_nempty),
    .head      (q_head)
  );

  ftpg_back #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .MAX_PROBES     (MAX_PROBES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_nempty     (q_nempty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .probe_index  (probe_index),
    .probe_number (probe_number),
    .filter_key   (filter_key),
    .last_probe   (out_tlast)
  );

  assign out_tdata = OUT_W'({filter_key, probe_number, probe_index});

`ifndef SYNTHESIS
  a_num_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && probe_number == $past(probe_number) + 1'b1)
    else $error("probe number did not advance within a run");

  a_run_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast && q_nempty |=>
      out_tvalid && probe_number == '0)
    else $error("queued run did not start right after last probe");

  a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> $stable(filter_key))
    else $error("filter key changed within a run");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_ready |-> !push)
    else $error("push into full queue");
`endif

endmodule

// File: tb/ftpg_probe_checker.sv
// ----------------------------------------------------------------------------
// ftpg_probe_checker: scoreboard for the filter table probe generator
// Snoops the register port, the tuple stream and the probe stream. Every
// accepted tuple is folded into its key and hashed, and its run of probes
// is queued. Every probe beat is checked field by field against the oldest
// queued probe.
// ----------------------------------------------------------------------------
module ftpg_probe_checker import ftpg_pkg::*; #(
  parameter int MAX_INDEX_BITS = 16,
  parameter int MAX_PROBES     = 64,
  parameter int OUT_W          = 56
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // source_address, source_port, dest_address, dst_port, queue_id, zero fill
  input  logic [111:0]         in_tdata,
  // is_tcp, full_match, is_transmit
  input  logic [2:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // probe_index, probe_number, filter_key, zero fill
  input  logic [OUT_W-1:0]     out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   tuples,
  output int                   probes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LFSR_W-1:0] index;
    logic [NUM_W-1:0]  number;
    logic [KEY_W-1:0]  key;
    logic              last;
  } probe_t;

  probe_t           due_probes[$];
  logic [TSL_W-1:0] size_log2 = TSL_RESET;
  logic [LIM_W-1:0] run_limit = LIM_RESET;
  int               n_bad = 0;
  int               n_tuples = 0;
  int               n_probes = 0;

  function automatic logic [KEY_W-1:0] fold_tuple_key(logic [111:0] d, logic [2:0] u);
    logic [31:0] sa, da;
    logic [15:0] sp, dp, t;
    logic [9:0]  q;
    logic        tcp, full, tx;
    sa = d[31:0];
    sp = d[47:32];
    da = d[79:48];
    dp = d[95:80];
    q  = d[105:96];
    tcp  = u[0];
    full = u[1];
    tx   = u[2];
    if (!tx) q = '0;
    if (!full) begin
      if (tx) begin
        da = '0;
        dp = '0;
      end else begin
        sa = '0;
        sp = '0;
      end
      // UDP wildcard: ports trade places
      if (!tcp) begin
        t  = sp;
        sp = dp;
        dp = t;
      end
    end
    return {21'd0, q, !tcp} ^ da ^ {dp, sa[31:16]} ^ {sa[15:0], sp};
  endfunction

  // x^16 + x^3 + 1, key shifted in MSB first
  function automatic logic [LFSR_W-1:0] lfsr_hash16(logic [KEY_W-1:0] key);
    logic [LFSR_W-1:0] r;
    r = LFSR_SEED;
    for (int i = KEY_W - 1; i >= 0; i--)
      r = {r[LFSR_W-2:0], r[15] ^ r[2] ^ key[i]};
    return r;
  endfunction

  function automatic void queue_probe_run(logic [111:0] d, logic [2:0] u);
    int                bits, lim;
    logic [16:0]       span;
    logic [LFSR_W-1:0] mask, idx, step;
    logic [KEY_W-1:0]  key, h2;
    probe_t            p;
    bits = (size_log2 > MAX_INDEX_BITS) ? MAX_INDEX_BITS : size_log2;
    span = (17'd1 << bits) - 17'd1;
    mask = span[LFSR_W-1:0];
    lim  = (run_limit == 0) ? 1 : (run_limit > MAX_PROBES) ? MAX_PROBES : run_limit;
    key  = fold_tuple_key(d, u);
    h2   = {key[KEY_W-2:0], 1'b0} - 32'd1;
    idx  = lfsr_hash16(key) & mask;
    step = h2[LFSR_W-1:0] & mask;
    for (int n = 0; n < lim; n++) begin
      p.index  = idx;
      p.number = NUM_W'(n);
      p.key    = key;
      p.last   = (n == lim - 1);
      due_probes.push_back(p);
      idx = (idx + step) & mask;
    end
  endfunction

  always @(posedge clk) begin
    probe_t            want;
    logic [LFSR_W-1:0] got_index;
    logic [NUM_W-1:0]  got_number;
    logic [KEY_W-1:0]  got_key;
    got_index  = out_tdata[15:0];
    got_number = out_tdata[21:16];
    got_key    = out_tdata[53:22];
    if (!rst_n) begin
      due_probes.delete();
      size_log2 = TSL_RESET;
      run_limit = LIM_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TABLE_SIZE_LOG2: size_log2 = cfg_data[TSL_W-1:0];
          REG_SEARCH_LIMIT:    run_limit = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        queue_probe_run(in_tdata, in_tuser);
        n_tuples++;
      end
      if (out_tvalid && out_tready) begin
        n_probes++;
        if (due_probes.size() == 0) begin
          if (n_bad < 10)
            $display("%0t: probe beat with nothing pending: idx %h num %0d key %h last %b",
                     $realtime, got_index, got_number, got_key, out_tlast);
          n_bad++;
        end else begin
          want = due_probes.pop_front();
          if (got_index !== want.index || got_number !== want.number ||
              got_key !== want.key || out_tlast !== want.last) begin
            if (n_bad < 10) begin
              $display("%0t: probe mismatch", $realtime);
              $display("  exp idx %h num %0d key %h last %b",
                       want.index, want.number, want.key, want.last);
              $display("  got idx %h num %0d key %h last %b",
                       got_index, got_number, got_key, out_tlast);
            end
            n_bad++;
          end
        end
      end
    end
    errors  <= n_bad;
    pending <= due_probes.size();
    tuples  <= n_tuples;
    probes  <= n_probes;
  end

endmodule

// File: tb/tb_filter_table_probe_generator_core.sv
// ----------------------------------------------------------------------------
// tb_filter_table_probe_generator_core: probe generator testbench
// Drives directed and random filter tuples across a series of register
// settings (empty and oversized tables, zero and oversized probe limits,
// writes to spare indexes) with bursty input and a stalling receiver,
// including one long output hold-off. Checking lives in ftpg_probe_checker.
// ----------------------------------------------------------------------------
module tb_filter_table_probe_generator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ftpg_pkg::*;

  localparam int OUT_W         = ((16 + NUM_W + KEY_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int NUM_PHASES    = 12;
  localparam int STEADY_PHASE  = 6;
  localparam int HOLD_PHASE    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB, RX_SPARSE} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [111:0]         in_tdata = '0;
  logic [2:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TABLE_SIZE_LOG2;
  logic [CFG_W-1:0]     cfg_data = '0;

  int       errors, pending, tuples, probes;
  int       cycle_cnt = 0;
  int       burst_left = 0;
  bit       steady = 1'b0;
  logic     hold_req = 1'b0;
  bit       hold_used = 1'b0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;

  filter_table_probe_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ftpg_probe_checker #(.OUT_W(OUT_W)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .tuples     (tuples),
    .probes     (probes)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d probes still pending", cycle_cnt, pending);
      $display("tb_filter_table_probe_generator_core: done, errors");
      $finish;
    end
  end

  // receiver: one long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 4));
        rx_left = $urandom_range(40, 300);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
        RX_COMB:   out_tready <= ((rx_phase % 5) < 2);
        default:   out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [31:0] pick_bits(int w);
    logic [31:0] m;
    m = (w >= 32) ? 32'hFFFF_FFFF : (32'd1 << w) - 32'd1;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return m;
      default: return $urandom() & m;
    endcase
  endfunction

  function automatic logic [111:0] pack_tuple(logic [31:0] sa, logic [15:0] sp,
                                              logic [31:0] da, logic [15:0] dp,
                                              logic [9:0] q);
    return {6'd0, q, dp, da, sp, sa};
  endfunction

  function automatic logic [111:0] random_tuple();
    return pack_tuple(pick_bits(32), 16'(pick_bits(16)), pick_bits(32),
                      16'(pick_bits(16)), 10'(pick_bits(10)));
  endfunction

  task automatic send_tuple(logic [111:0] d, logic [2:0] u);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= u;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // sender pause until every queued probe has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_W-1:0] size_val, logic [CFG_W-1:0] limit_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TABLE_SIZE_LOG2;
    cfg_data  <= size_val;
    @(posedge clk);
    cfg_index <= REG_SEARCH_LIMIT;
    cfg_data  <= limit_val;
    @(posedge clk);
    // spare index, must be ignored
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_0 : REG_SPARE_1;
    cfg_data  <= CFG_W'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] size_set[NUM_PHASES];
    logic [CFG_W-1:0] limit_set[NUM_PHASES];
    int               item_cnt[NUM_PHASES];
    logic [111:0]     pattern;
    size_set  = '{7'd16, 7'd1, 7'd0, 7'd127, 7'd20, 7'd5, 7'd16, 7'd10, 7'd13, 7'd0, 7'd0,
                  7'd15};
    limit_set = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd3, 7'd1, 7'd2, 7'd8, 7'd0, 7'd0,
                  7'd4};
    item_cnt  = '{15, 60, 40, 12, 12, 50, 60, 55, 50, 50, 20, 36};
    size_set[9]   = CFG_W'($urandom_range(0, 127));
    limit_set[9]  = CFG_W'($urandom_range(1, 16));
    size_set[10]  = CFG_W'($urandom_range(0, 127));
    limit_set[10] = CFG_W'($urandom_range(0, 127));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed tuples at reset register values
    pattern = pack_tuple(32'h1234_5678, 16'h9ABC, 32'hDEF0_1234, 16'h5678, 10'h3FF);
    for (int u = 0; u < 8; u++)
      send_tuple(pattern, 3'(u));
    pattern = pack_tuple('1, '1, '1, '1, '1);
    send_tuple(pattern, 3'b111);
    send_tuple(pattern, 3'b000);
    send_tuple(pattern, 3'b010);
    send_tuple(pattern, 3'b101);
    send_tuple('0, 3'b000);
    send_tuple('0, 3'b111);
    pattern = pack_tuple('0, '0, '0, '0, 10'h3FF);
    send_tuple(pattern, 3'b111);
    send_tuple(pattern, 3'b011);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_regs(size_set[ph], limit_set[ph]);
      steady = (ph == STEADY_PHASE) || (ph == HOLD_PHASE);
      if (ph == HOLD_PHASE)
        hold_req <= 1'b1;
      for (int k = 0; k < item_cnt[ph]; k++)
        send_tuple(random_tuple(), 3'($urandom_range(0, 7)));
      settle();
    end

    $display("%0d tuples and %0d probes checked over %0d register settings",
             tuples, probes, NUM_PHASES + 1);
    $display("incl. empty/oversized table, zero/oversized limit, spare writes, long stall");
    if (errors == 0)
      $display("tb_filter_table_probe_generator_core: done, clean");
    else
      $display("tb_filter_table_probe_generator_core: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
sv/ftpg_pkg.sv
sv/ftpg_front.sv
sv/ftpg_queue.sv
sv/ftpg_back.sv
sv/filter_table_probe_generator_core.sv
tb/ftpg_probe_checker.sv
tb/tb_filter_table_probe_generator_core.sv
